@@ hw/rtl/tdpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpt_pkg - shared types and constants for the trial division prime tester
// Control state codes and the state vector type.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  typedef logic [1:0] tdpt_state_t;

  localparam tdpt_state_t ST_IDLE  = 2'd0;
  localparam tdpt_state_t ST_CHECK = 2'd1;
  localparam tdpt_state_t ST_DIV   = 2'd2;
  localparam tdpt_state_t ST_DONE  = 2'd3;

  localparam int unsigned FIELD_BITS = 32;

endpackage

`default_nettype wire

@@ hw/rtl/trial_division_prime_test_top.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test_top - primality test by trial division
// One candidate per input beat, one verdict per output beat.
// ----------------------------------------------------------------------------
// Each input beat carries a candidate; the low VALUE_BITS bits are tested and
// echoed on the result beat with is_prime. Values below 4 and even values
// are decided directly. Larger odd values are divided by 3, 5, 7, ...
// while the divisor squared does not exceed the value; each trial is a
// restoring remainder that shifts in one dividend bit per cycle. A composite
// stops at its smallest odd factor. One candidate is worked on at a time; the
// result register lets the next candidate enter while the previous verdict
// waits on out_stall.
`default_nettype none

module trial_division_prime_test_top
  import tdpt_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [FIELD_BITS-1:0] in_candidate,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [FIELD_BITS-1:0]      out_tested_value,
  output logic                       out_is_prime
);

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned EW  = (VB > FIELD_BITS) ? VB : FIELD_BITS;
  localparam int unsigned SQW = VB + 2;
  localparam int unsigned CW  = $clog2(VB);
  localparam logic [CW-1:0] CNT_LAST = CW'(VB - 1);

  tdpt_state_t       state_r, state_nxt;
  logic [VB-1:0]     n_r, n_nxt;
  logic [VB-1:0]     d_r, d_nxt;
  logic [SQW-1:0]    sq_r, sq_nxt;
  logic [VB-1:0]     q_r, q_nxt;
  logic [VB-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              prime_r, prime_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VB-1:0]     res_val_r, res_val_nxt;
  logic              res_prime_r, res_prime_nxt;

  logic [EW-1:0]     cand_ext;
  logic [VB-1:0]     n_in;
  logic [EW-1:0]     echo_ext;
  logic [VB:0]       trial;
  logic [VB:0]       trial_sub;
  logic [VB-1:0]     rem_step;
  logic              in_fire;
  logic              out_fire;
  logic              out_free;

  assign cand_ext  = EW'(in_candidate);
  assign n_in      = cand_ext[VB-1:0];
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign trial     = {rem_r, q_r[VB-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign rem_step  = trial_sub[VB] ? trial[VB-1:0] : trial_sub[VB-1:0];

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    prime_nxt     = prime_r;
    out_valid_nxt = out_valid_r;
    res_val_nxt   = res_val_r;
    res_prime_nxt = res_prime_r;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          n_nxt = n_in;
          d_nxt = VB'(3);
          sq_nxt = SQW'(9);
          priority if (n_in < VB'(2)) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else if (n_in < VB'(4)) begin
            prime_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (!n_in[0]) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_r > SQW'(n_r)) begin
          prime_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          q_nxt     = n_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        q_nxt   = q_r << 1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          if (rem_step == '0) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            d_nxt     = d_r + VB'(2);
            sq_nxt    = sq_r + (SQW'(d_r) << 2) + SQW'(4);
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_val_nxt   = n_r;
          res_prime_nxt = prime_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    prime_r     <= prime_nxt;
    res_val_r   <= res_val_nxt;
    res_prime_r <= res_prime_nxt;
  end

  assign echo_ext         = EW'(res_val_r);
  assign out_valid        = out_valid_r;
  assign out_tested_value = echo_ext[FIELD_BITS-1:0];
  assign out_is_prime     = res_prime_r;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("core idle after accepting a candidate");

  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (d_r[0] && (d_r >= VB'(3))))
    else $error("trial divisor not odd or below three");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("partial remainder not below divisor");

  a_check_sq: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CHECK) && (sq_r <= SQW'(n_r))) |=> (state_r == ST_DIV))
    else $error("trial not started with divisor square in range");
`endif

endmodule

`default_nettype wire

@@ tb/sv/trial_division_prime_test_top_test.sv @@
// ----------------------------------------------------------------------------
// trial_division_prime_test_top_test - testbench for the trial division tester
// Sends candidates through the valid/stall input channel and checks each
// verdict against a trial-division predictor inside the bench: the echoed
// value and the prime flag, in order. A directed set covers zero, one, two,
// squares of primes and the ends of the 32-bit range. The random set keeps
// the big values cheap by giving them a small odd factor. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trial_division_prime_test_top_test;
  import tdpt_pkg::*;

  localparam int unsigned VALUE_BITS = 32;
  localparam logic [63:0] CAND_MASK  = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
  localparam int N_RANDOM   = 77;
  localparam int TAIL       = 20;
  localparam int LONG_HOLD  = 300;
  localparam int DRAIN      = 100;
  localparam int QUIET_MAX  = 500000;

  typedef struct {
    logic [FIELD_BITS-1:0] value;
    logic                  prime;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FIELD_BITS-1:0] in_candidate = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FIELD_BITS-1:0] out_tested_value;
  logic                  out_is_prime;

  logic [FIELD_BITS-1:0] candidates[$];
  verdict_t              verdicts_due[$];
  verdict_t              due;
  logic [63:0]           masked;
  int                    n_items = 0;
  int                    beats_sent = 0;
  int                    beats_seen = 0;
  int                    err_cnt = 0;
  int                    send_gap = 0;
  int                    stall_left = 0;
  int                    hold_left = 0;
  bit                    hold_done = 1'b0;
  bit                    send_idle_on = 1'b1;
  bit                    recv_idle_on = 1'b1;
  int                    quiet_cycles = 0;

  trial_division_prime_test_top #(
    .VALUE_BITS (VALUE_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tested_value (out_tested_value),
    .out_is_prime     (out_is_prime)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic prime_by_trial(logic [63:0] n);
    logic [63:0] d;
    if (n < 64'd2) return 1'b0;
    if (n < 64'd4) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 64'd3; d <= n / d; d += 64'd2) begin
      if (n % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_candidate <= '0;
      send_gap     = 0;
    end else begin
      if (in_valid && !in_stall) begin
        masked = 64'(in_candidate) & CAND_MASK;
        verdicts_due.push_back('{value: masked[FIELD_BITS-1:0], prime: prime_by_trial(masked)});
        beats_sent++;
      end
      if ($urandom_range(0, 49) == 0) send_idle_on = !send_idle_on;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (candidates.size() > 0) begin
          in_valid     <= 1'b1;
          in_candidate <= candidates.pop_front();
          if (send_idle_on && candidates.size() > TAIL && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result beat: tested_value %0d", out_tested_value);
          err_cnt++;
        end else begin
          due = verdicts_due.pop_front();
          if (out_tested_value !== due.value) begin
            $error("tested_value: expected %0d, got %0d", due.value, out_tested_value);
            err_cnt++;
          end
          if (out_is_prime !== due.prime) begin
            $error("is_prime: expected %0b, got %0b (value %0d)", due.prime, out_is_prime,
                   due.value);
            err_cnt++;
          end
        end
        beats_seen++;
      end
      if ($urandom_range(0, 49) == 0) recv_idle_on = !recv_idle_on;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_seen == 3) begin
        // long hold-off so the block backs up into its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (recv_idle_on && beats_seen < n_items - TAIL && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [FIELD_BITS-1:0] v;
    int                    f;
    int                    kind;
    bit                    has_small;

    // small values first so the long hold-off lands on a busy block
    candidates = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd121,
                   32'd97, 32'd6, 32'd15, 32'd65521, 32'd65537, 32'd1048573, 32'd16752649,
                   32'd16777213, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h5555_5555,
                   32'hAAAA_AAAA};
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        v = $urandom_range(0, 4095);
      end else if (kind < 7) begin
        v = $urandom_range(0, 65535);
      end else begin
        // wide value, forced to have a small factor to bound the trial count
        v = $urandom;
        has_small = 1'b0;
        for (int d = 3; d <= 101; d += 2) begin
          if (v % d == 0) has_small = 1'b1;
        end
        if (v[0] && !has_small) begin
          f = 2 * $urandom_range(1, 50) + 1;
          v = (v / f) * f;
        end
      end
      candidates.push_back(v);
    end
    n_items = candidates.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (beats_sent < n_items || verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_cnt == 0 && verdicts_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
